// ----- rtl/core/ffba_pkg.sv -----
// ffba_pkg: types, constants and codes shared by the block allocator core
// no dependencies; used by ffba_ctrl, ffba_datapath and the top level
`default_nettype none

package ffba_pkg;

	// heap geometry
	localparam int BLOCK_BYTES   = 4096;
	localparam int TABLE_ENTRIES = 1024;
	localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int ADDR_W        = 32;
	localparam int OFF_W         = ADDR_W - BLOCK_SHIFT;
	localparam int NEED_W        = ADDR_W + 1 - BLOCK_SHIFT;
	localparam int BYTES_W       = 23;

	// configuration registers
	localparam int BIU_W = 11;
	localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;
	localparam logic REG_BASE_ADDRESS  = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	// operation codes
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_SIZE  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] request_bytes;
		logic [ADDR_W-1:0] block_address;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ADDR_W-1:0]  result_address;
		logic [BYTES_W-1:0] result_bytes;
	} result_t;

	// one table entry: taken in bit 0
	typedef struct packed {
		logic has_next;
		logic first;
		logic taken;
	} entry_t;

	typedef enum logic [2:0] {
		RES_ALLOC_OK,
		RES_FAIL,
		RES_RANGE,
		RES_FREE_OK,
		RES_SIZE_OK
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      clr_step;
		logic      walk_init;
		logic      scan_step;
		logic      mark_step;
		logic      free_step;
		logic      size_step;
		logic      finish;
		res_kind_t kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       need_zero;
		logic       heap_empty;
		logic       addr_ok;
		logic       clr_last;
		logic       found;
		logic       more;
		logic       free_cont;
		logic       size_cont;
		logic       mark_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_core.sv -----
// first_fit_block_allocator_core: config registers, controller and datapath; uses ffba_pkg
// Steps: an accepted request passes through decode, then any table walk (scan and mark
// for allocate, a chain walk for free and size query), then the response state, and the
// strobe rises as the response state is left. The receiver cannot stall results. One
// request at a time: busy falls as the strobe rises. Reset: busy high during a clearing
// sweep of the table; base 0, 1024 blocks.
`default_nettype none

module first_fit_block_allocator_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// request and result
	input  wire logic                        start,
	output logic                             busy,
	input  wire ffba_pkg::request_t          request,
	output logic                             done,
	output ffba_pkg::result_t                result
);

	logic [ffba_pkg::ADDR_W-1:0] base_q;
	logic [ffba_pkg::BIU_W-1:0]  biu_q;
	logic [ffba_pkg::CNT_W-1:0]  used;
	logic                        wr_hit;
	ffba_pkg::dp_cmd_t           cmd;
	ffba_pkg::dp_stat_t          stat;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			biu_q  <= ffba_pkg::BIU_RESET;
		end else if (wr_hit) begin
			unique case (paddr[2])
				ffba_pkg::REG_BASE_ADDRESS:  base_q <= pwdata;
				ffba_pkg::REG_BLOCKS_IN_USE: biu_q  <= pwdata[ffba_pkg::BIU_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[2])
			ffba_pkg::REG_BLOCKS_IN_USE: prdata = 32'(biu_q);
			default:                     prdata = base_q;
		endcase
	end

	// table entries actually covered by the heap
	assign used = (biu_q > ffba_pkg::BIU_W'(ffba_pkg::TABLE_ENTRIES))
		? ffba_pkg::CNT_W'(ffba_pkg::TABLE_ENTRIES)
		: ffba_pkg::CNT_W'(biu_q);

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	ffba_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.request      (request),
		.base_address (base_q),
		.used         (used),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- rtl/core/ffba_datapath.sv -----
// ffba_datapath: block table memory, walk cursor, run and chain counters, result register
// depends on ffba_pkg; sequenced by ffba_ctrl
`default_nettype none

module ffba_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffba_pkg::dp_cmd_t           cmd,
	output ffba_pkg::dp_stat_t               stat,
	input  wire ffba_pkg::request_t          request,
	input  wire logic [ffba_pkg::ADDR_W-1:0] base_address,
	input  wire logic [ffba_pkg::CNT_W-1:0]  used,
	output ffba_pkg::result_t                result
);

	// block table, no reset: cleared by a sweep after reset
	ffba_pkg::entry_t mem [ffba_pkg::TABLE_ENTRIES];
	ffba_pkg::entry_t rdata_q;

	logic [1:0]                  mode_q;
	logic [ffba_pkg::ADDR_W-1:0] addr_q;
	logic [ffba_pkg::NEED_W-1:0] need_q;
	logic [ffba_pkg::IDX_W-1:0]  cur_q;
	logic [ffba_pkg::IDX_W-1:0]  start_q;
	logic [ffba_pkg::CNT_W-1:0]  run_q;
	logic [ffba_pkg::CNT_W-1:0]  remain_q;
	logic [ffba_pkg::CNT_W-1:0]  count_q;
	logic                        first_q;
	ffba_pkg::result_t           result_q;

	logic [ffba_pkg::IDX_W-1:0]  cur_nxt;
	logic [ffba_pkg::ADDR_W-1:0] diff;
	logic [ffba_pkg::OFF_W-1:0]  off;
	logic [ffba_pkg::IDX_W-1:0]  walk_start;
	logic [ffba_pkg::CNT_W-1:0]  run_n;
	logic [ffba_pkg::IDX_W-1:0]  start_n;
	logic                        size_accept;
	logic                        rd_en;
	logic [ffba_pkg::IDX_W-1:0]  rd_addr;
	logic                        wr_en;
	ffba_pkg::entry_t            wr_data;
	logic [ffba_pkg::ADDR_W:0]   need_sum;
	ffba_pkg::result_t           res_n;

	// address to block index
	assign diff       = addr_q - base_address;
	assign off        = diff[ffba_pkg::ADDR_W-1:ffba_pkg::BLOCK_SHIFT];
	assign walk_start = (mode_q == ffba_pkg::MODE_ALLOC) ? '0 : off[ffba_pkg::IDX_W-1:0];
	assign cur_nxt    = cur_q + 1'b1;

	// round the byte count up to blocks
	assign need_sum = {1'b0, request.request_bytes}
		+ (ffba_pkg::ADDR_W+1)'(ffba_pkg::BLOCK_BYTES - 1);

	// first-fit run tracking
	assign run_n   = rdata_q.taken ? '0 : run_q + 1'b1;
	assign start_n = (!rdata_q.taken && run_q == '0) ? cur_q : start_q;

	// chain step accepted when it is the start entry or a taken middle entry
	assign size_accept = first_q || (rdata_q.taken && !rdata_q.first);

	// status towards the controller
	always_comb begin
		stat.mode       = mode_q;
		stat.need_zero  = (need_q == '0);
		stat.heap_empty = (used == '0);
		stat.addr_ok    = (addr_q >= base_address) && (off < ffba_pkg::OFF_W'(used));
		stat.clr_last   = (cur_q == ffba_pkg::IDX_W'(ffba_pkg::TABLE_ENTRIES - 1));
		stat.found      = !rdata_q.taken && (ffba_pkg::NEED_W'(run_n) == need_q);
		stat.more       = ({1'b0, cur_q} + 1'b1) < used;
		stat.free_cont  = rdata_q.has_next && stat.more;
		stat.size_cont  = size_accept && rdata_q.has_next && stat.more;
		stat.mark_last  = (remain_q == ffba_pkg::CNT_W'(1));
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_nxt;
		wr_en   = 1'b0;
		wr_data = '0;
		if (cmd.walk_init) begin
			rd_en   = 1'b1;
			rd_addr = walk_start;
		end
		if (cmd.scan_step && !stat.found && stat.more) begin
			rd_en = 1'b1;
		end
		if (cmd.free_step) begin
			wr_en = 1'b1;
			rd_en = stat.free_cont;
		end
		if (cmd.size_step) begin
			rd_en = stat.size_cont;
		end
		if (cmd.mark_step) begin
			wr_en            = 1'b1;
			wr_data.taken    = 1'b1;
			wr_data.first    = (cur_q == start_q);
			wr_data.has_next = !stat.mark_last;
		end
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cur_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= request.mode;
			addr_q <= request.block_address;
			need_q <= need_sum[ffba_pkg::ADDR_W:ffba_pkg::BLOCK_SHIFT];
		end
	end

	// cursor, starts at zero for the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.walk_init) begin
			cur_q <= walk_start;
		end else if (cmd.scan_step && stat.found) begin
			cur_q <= start_n;
		end else if (cmd.clr_step || cmd.mark_step || (cmd.scan_step && stat.more)
			|| (cmd.free_step && stat.free_cont) || (cmd.size_step && stat.size_cont)) begin
			cur_q <= cur_nxt;
		end
	end

	// run, chain and mark counters
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			run_q   <= '0;
			count_q <= '0;
			first_q <= 1'b1;
			start_q <= '0;
		end
		if (cmd.scan_step) begin
			run_q   <= run_n;
			start_q <= start_n;
			if (stat.found) begin
				remain_q <= run_n;
			end
		end
		if (cmd.mark_step) begin
			remain_q <= remain_q - 1'b1;
		end
		if (cmd.size_step) begin
			first_q <= 1'b0;
			if (size_accept) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// result value; sizes stay within the heap so no saturation is reached
	always_comb begin
		res_n = '0;
		unique case (cmd.kind)
			ffba_pkg::RES_ALLOC_OK: begin
				res_n.status         = ffba_pkg::STATUS_OK;
				res_n.result_address = base_address
					+ (ffba_pkg::ADDR_W'(start_q) << ffba_pkg::BLOCK_SHIFT);
				res_n.result_bytes   = ffba_pkg::BYTES_W'(run_q)
					<< ffba_pkg::BLOCK_SHIFT;
			end
			ffba_pkg::RES_SIZE_OK: begin
				res_n.status       = ffba_pkg::STATUS_OK;
				res_n.result_bytes = ffba_pkg::BYTES_W'(count_q)
					<< ffba_pkg::BLOCK_SHIFT;
			end
			ffba_pkg::RES_FREE_OK: res_n.status = ffba_pkg::STATUS_OK;
			ffba_pkg::RES_RANGE:   res_n.status = ffba_pkg::STATUS_RANGE;
			default:               res_n.status = ffba_pkg::STATUS_FAIL;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= res_n;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// ----- rtl/core/ffba_ctrl.sv -----
// ffba_ctrl: sequencer for clearing, scanning, marking and chain walks
// depends on ffba_pkg; drives ffba_datapath through command and status structs
`default_nettype none

module ffba_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output ffba_pkg::dp_cmd_t       cmd,
	input  wire ffba_pkg::dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MARK,
		S_FREE,
		S_SIZE,
		S_RESP
	} state_t;

	state_t              state_q;
	ffba_pkg::res_kind_t kind_q;
	logic                done_q;
	logic                go_walk;

	// decode decides whether a table walk is needed
	always_comb begin
		unique case (stat.mode)
			ffba_pkg::MODE_ALLOC: go_walk = !stat.need_zero && !stat.heap_empty;
			ffba_pkg::MODE_FREE:  go_walk = stat.addr_ok;
			ffba_pkg::MODE_SIZE:  go_walk = stat.addr_ok;
			default:              go_walk = 1'b0;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.kind      = kind_q;
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.clr_step  = (state_q == S_CLEAR);
		cmd.walk_init = (state_q == S_DECODE) && go_walk;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.mark_step = (state_q == S_MARK);
		cmd.free_step = (state_q == S_FREE);
		cmd.size_step = (state_q == S_SIZE);
		cmd.finish    = (state_q == S_RESP);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q  <= ffba_pkg::RES_FAIL;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= S_DECODE;
				end
				S_DECODE: begin
					unique case (stat.mode)
						ffba_pkg::MODE_ALLOC: begin
							state_q <= go_walk ? S_SCAN : S_RESP;
							kind_q  <= ffba_pkg::RES_FAIL;
						end
						ffba_pkg::MODE_FREE: begin
							state_q <= go_walk ? S_FREE : S_RESP;
							kind_q  <= ffba_pkg::RES_RANGE;
						end
						ffba_pkg::MODE_SIZE: begin
							state_q <= go_walk ? S_SIZE : S_RESP;
							kind_q  <= ffba_pkg::RES_RANGE;
						end
						default: begin
							state_q <= S_RESP;
							kind_q  <= ffba_pkg::RES_FAIL;
						end
					endcase
				end
				S_SCAN: begin
					priority if (stat.found) begin
						state_q <= S_MARK;
					end else if (!stat.more) begin
						state_q <= S_RESP;
						kind_q  <= ffba_pkg::RES_FAIL;
					end
				end
				S_MARK: begin
					if (stat.mark_last) begin
						state_q <= S_RESP;
						kind_q  <= ffba_pkg::RES_ALLOC_OK;
					end
				end
				S_FREE: begin
					if (!stat.free_cont) begin
						state_q <= S_RESP;
						kind_q  <= ffba_pkg::RES_FREE_OK;
					end
				end
				S_SIZE: begin
					if (!stat.size_cont) begin
						state_q <= S_RESP;
						kind_q  <= ffba_pkg::RES_SIZE_OK;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a strobe only follows the response state
	a_done_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_RESP))
		else $error("result strobe without response state");

	// an accepted request always goes to decode
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DECODE))
		else $error("accepted request not decoded");

	// at most one table operation per cycle
	a_one_table_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.walk_init, cmd.scan_step, cmd.mark_step,
			cmd.free_step, cmd.size_step}))
		else $error("conflicting table commands");

	// one strobe per request
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("repeated result strobe");

endmodule

`default_nettype wire

// ----- tb/first_fit_block_allocator_core_test.sv -----
// first_fit_block_allocator_core_test: self-checking bench for the first-fit block allocator
// predicts each result from its own copy of the block table and compares on the done strobe
// depends on ffba_pkg and first_fit_block_allocator_core
`default_nettype none

module first_fit_block_allocator_core_test;

	localparam logic [2:0] ADDR_BASE_REG = {ffba_pkg::REG_BASE_ADDRESS, 2'b00};
	localparam logic [2:0] ADDR_BIU_REG  = {ffba_pkg::REG_BLOCKS_IN_USE, 2'b00};
	localparam logic [ffba_pkg::BYTES_W-1:0] BYTES_CAP = '1;
	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int         STALL_LIMIT   = 20000;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [2:0]         paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start   = 1'b0;
	logic               busy;
	ffba_pkg::request_t request = '0;
	logic               done;
	ffba_pkg::result_t  result;

	// predictor state: block table copy and register shadows
	ffba_pkg::entry_t                block_map [ffba_pkg::TABLE_ENTRIES];
	logic [ffba_pkg::ADDR_W-1:0]     base_sh   = '0;
	logic [ffba_pkg::BIU_W-1:0]      blocks_sh = ffba_pkg::BIU_RESET;

	ffba_pkg::request_t              pending_requests [$];
	ffba_pkg::result_t               expected_results [$];
	logic [ffba_pkg::ADDR_W-1:0]     live_starts [$];

	int idle_pct     = 26;
	int common_blk   = 1;
	int max_blk      = 1;
	int error_count  = 0;
	int stall_cycles = 0;

	first_fit_block_allocator_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #5 clk = ~clk;

	function automatic int unsigned heap_blocks();
		return (blocks_sh > ffba_pkg::TABLE_ENTRIES) ? ffba_pkg::TABLE_ENTRIES : int'(blocks_sh);
	endfunction

	function automatic logic [ffba_pkg::BYTES_W-1:0] cap_bytes(input logic [63:0] n);
		return (n > 64'(BYTES_CAP)) ? BYTES_CAP : n[ffba_pkg::BYTES_W-1:0];
	endfunction

	function automatic logic [ffba_pkg::ADDR_W-1:0] block_addr(input int unsigned idx);
		return base_sh + 32'(idx) * 32'(ffba_pkg::BLOCK_BYTES);
	endfunction

	// expected result of one request; updates the block table copy
	function automatic ffba_pkg::result_t predict_result(ffba_pkg::request_t rq);
		ffba_pkg::result_t res;
		int unsigned       used, need_blk, run_len, run_start, ix, idx, cnt;
		logic [63:0]       need_wide, off_wide;
		bit                found, hit, walking;
		ffba_pkg::entry_t  ent;
		res        = '0;
		res.status = ffba_pkg::STATUS_FAIL;
		used       = heap_blocks();
		hit        = 1'b0;
		idx        = 0;
		if (64'(rq.block_address) >= 64'(base_sh)) begin
			off_wide = (64'(rq.block_address) - 64'(base_sh)) / ffba_pkg::BLOCK_BYTES;
			if (off_wide < 64'(used)) begin
				hit = 1'b1;
				idx = int'(off_wide);
			end
		end
		case (rq.mode)
			ffba_pkg::MODE_ALLOC: begin
				need_wide = (64'(rq.request_bytes) + ffba_pkg::BLOCK_BYTES - 1)
					/ ffba_pkg::BLOCK_BYTES;
				// a run longer than the heap can never be found
				if (need_wide != 0 && need_wide <= 64'(used)) begin
					need_blk  = int'(need_wide);
					run_len   = 0;
					run_start = 0;
					found     = 1'b0;
					for (ix = 0; ix < used && !found; ix++) begin
						if (block_map[ix].taken) begin
							run_len = 0;
						end else begin
							if (run_len == 0)
								run_start = ix;
							run_len++;
							if (run_len == need_blk)
								found = 1'b1;
						end
					end
					if (found) begin
						for (ix = run_start; ix < run_start + need_blk; ix++) begin
							block_map[ix].taken    = 1'b1;
							block_map[ix].first    = (ix == run_start);
							block_map[ix].has_next = (ix + 1 < run_start + need_blk);
						end
						res.status         = ffba_pkg::STATUS_OK;
						res.result_address = block_addr(run_start);
						res.result_bytes   = cap_bytes(64'(need_blk) * ffba_pkg::BLOCK_BYTES);
					end
				end
			end
			ffba_pkg::MODE_FREE: begin
				if (!hit) begin
					res.status = ffba_pkg::STATUS_RANGE;
				end else begin
					// clear through the last block of the chain
					walking = 1'b1;
					for (ix = idx; ix < used && walking; ix++) begin
						ent           = block_map[ix];
						block_map[ix] = '0;
						walking       = ent.has_next;
					end
					res.status = ffba_pkg::STATUS_OK;
				end
			end
			ffba_pkg::MODE_SIZE: begin
				if (!hit) begin
					res.status = ffba_pkg::STATUS_RANGE;
				end else begin
					cnt = 1;
					ix  = idx;
					while (block_map[ix].has_next && ix + 1 < used &&
					       block_map[ix+1].taken && !block_map[ix+1].first) begin
						ix++;
						cnt++;
					end
					res.status       = ffba_pkg::STATUS_OK;
					res.result_bytes = cap_bytes(64'(cnt) * ffba_pkg::BLOCK_BYTES);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// random request: mostly allocate and free of live allocations, some noise
	function automatic ffba_pkg::request_t make_request();
		ffba_pkg::request_t          rq;
		int unsigned                 used, pick, sel, nblk;
		logic [ffba_pkg::ADDR_W-1:0] addr;
		used             = heap_blocks();
		rq.mode          = ffba_pkg::MODE_ALLOC;
		rq.request_bytes = $urandom;
		rq.block_address = $urandom;
		pick             = $urandom_range(0, 99);
		if (pick < 38) begin
			sel = $urandom_range(0, 15);
			if (sel == 0) begin
				rq.request_bytes = '0;
			end else if (sel == 1) begin
				// random size, nearly always far too large
			end else if (sel == 2) begin
				rq.request_bytes = $urandom_range(1, max_blk) * ffba_pkg::BLOCK_BYTES;
			end else begin
				nblk = (sel == 3) ? $urandom_range(1, max_blk) : $urandom_range(1, common_blk);
				rq.request_bytes = (nblk - 1) * ffba_pkg::BLOCK_BYTES
					+ $urandom_range(1, ffba_pkg::BLOCK_BYTES);
			end
		end else if (pick < 82) begin
			rq.mode = (pick < 62) ? ffba_pkg::MODE_FREE : ffba_pkg::MODE_SIZE;
			if (live_starts.size() != 0 && $urandom_range(0, 9) < 7) begin
				addr = live_starts[$urandom_range(0, live_starts.size() - 1)];
				if (rq.mode == ffba_pkg::MODE_SIZE)
					addr = addr + $urandom_range(0, 2) * ffba_pkg::BLOCK_BYTES;
				if ($urandom_range(0, 3) == 0)
					addr = addr + $urandom_range(1, ffba_pkg::BLOCK_BYTES - 1);
				rq.block_address = addr;
			end else if (used != 0) begin
				rq.block_address = block_addr($urandom_range(0, used - 1));
			end
		end else begin
			sel     = $urandom_range(0, 5);
			rq.mode = $urandom_range(0, 1) ? ffba_pkg::MODE_FREE : ffba_pkg::MODE_SIZE;
			case (sel)
				0:       rq.mode = MODE_RESERVED;
				3:       rq.block_address = base_sh - 1;
				4:       rq.block_address = block_addr(used);
				5:       rq.block_address = block_addr(used) - 1;
				default: ;
			endcase
		end
		return rq;
	endfunction

	function automatic void add_request(input logic [1:0] mode, input logic [31:0] bytes,
	                                    input logic [31:0] addr);
		ffba_pkg::request_t rq;
		rq.mode          = mode;
		rq.request_bytes = bytes;
		rq.block_address = addr;
		pending_requests.push_back(rq);
	endfunction

	// register write over the configuration port: setup, access, then the write edge
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_BASE_REG)
			base_sh = data;
		else
			blocks_sh = data[ffba_pkg::BIU_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every request is taken and every result has come back
	task automatic settle();
		while (pending_requests.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] base, input logic [ffba_pkg::BIU_W-1:0] blocks,
	                         input int n_items, input int idle, input int common,
	                         input int biggest);
		write_reg(ADDR_BASE_REG, base);
		write_reg(ADDR_BIU_REG, 32'(blocks));
		live_starts.delete();
		idle_pct   = idle;
		common_blk = common;
		max_blk    = biggest;
		for (int n = 0; n < n_items; n++) begin
			while (pending_requests.size() >= 2)
				@(negedge clk);
			pending_requests.push_back(make_request());
			// halfway through, the sender holds off until the block has drained
			if (n == n_items / 2)
				settle();
		end
		settle();
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(predict_result(request));
				if (expected_results[$].status == ffba_pkg::STATUS_OK) begin
					if (request.mode == ffba_pkg::MODE_ALLOC) begin
						live_starts.push_back(expected_results[$].result_address);
						if (live_starts.size() > 256)
							void'(live_starts.pop_front());
					end else if (request.mode == ffba_pkg::MODE_FREE) begin
						for (int k = live_starts.size() - 1; k >= 0; k--)
							if (live_starts[k] == request.block_address)
								live_starts.delete(k);
					end
				end
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					start   <= 1'b1;
					request <= pending_requests.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result strobe with no request outstanding");
				error_count++;
			end else begin
				if (result.status !== expected_results[0].status) begin
					$error("status mismatch: expected %0d, actual %0d",
					       expected_results[0].status, result.status);
					error_count++;
				end
				if (result.result_address !== expected_results[0].result_address) begin
					$error("result_address mismatch: expected %h, actual %h",
					       expected_results[0].result_address, result.result_address);
					error_count++;
				end
				if (result.result_bytes !== expected_results[0].result_bytes) begin
					$error("result_bytes mismatch: expected %h, actual %h",
					       expected_results[0].result_bytes, result.result_bytes);
					error_count++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// stimulus
	initial begin
		foreach (block_map[k])
			block_map[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small heap of eight blocks
		write_reg(ADDR_BASE_REG, 32'h0010_0000);
		write_reg(ADDR_BIU_REG, 32'd8);
		add_request(ffba_pkg::MODE_ALLOC, 32'd0, 32'h0);
		add_request(ffba_pkg::MODE_ALLOC, 32'd1, 32'hFFFF_FFFF);
		add_request(ffba_pkg::MODE_ALLOC, 32'd4096, 32'h0);
		add_request(ffba_pkg::MODE_ALLOC, 32'd4097, 32'h0);
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_0000);
		// unaligned address inside a two-block allocation
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_2123);
		// second and last block of the two-block allocation
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_3000);
		add_request(ffba_pkg::MODE_FREE, 32'h0, 32'h0010_1000);
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_1000);
		// free of a block that is already free
		add_request(ffba_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'h0010_1000);
		add_request(ffba_pkg::MODE_ALLOC, 32'd12288, 32'h0);
		// only single free blocks left, one cut off at the heap end
		add_request(ffba_pkg::MODE_ALLOC, 32'd8192, 32'h0);
		add_request(ffba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'h0);
		add_request(ffba_pkg::MODE_FREE, 32'h0, 32'h0);
		add_request(ffba_pkg::MODE_FREE, 32'h0, 32'h0010_8000);
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'hFFFF_FFFF);
		add_request(MODE_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(ffba_pkg::MODE_FREE, 32'h0, 32'h0010_2000);
		add_request(ffba_pkg::MODE_ALLOC, 32'd8192, 32'h0);
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_3000);
		// free from the middle of a chain
		add_request(ffba_pkg::MODE_FREE, 32'h0, 32'h0010_5000);
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_4000);
		add_request(ffba_pkg::MODE_FREE, 32'h0, 32'h000F_FFFF);
		add_request(ffba_pkg::MODE_SIZE, 32'h0, 32'h0010_7FFF);
		settle();

		// random phases over a range of heap settings
		run_phase(32'h0000_0000, 11'd1, 30, 26, 1, 2);
		run_phase(32'hFFFF_F000, 11'd16, 60, 26, 3, 16);
		run_phase(32'h1234_5678, 11'd40, 90, 0, 4, 40);
		run_phase(32'hFFFF_FFFF, 11'd0, 20, 26, 2, 4);
		run_phase(32'h8000_0000, 11'd2047, 40, 26, 8, 1024);
		run_phase(32'h0004_0000, 11'd1024, 40, 26, 16, 1024);
		run_phase(32'h0000_0000, 11'd24, 180, 26, 3, 24);
		run_phase($urandom & 32'hFFFF_F000, 11'd64, 100, 26, 6, 64);

		repeat (16) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
